// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/spq_pkg.sv =====
`default_nettype none
package spq_pkg;
   localparam int unsigned PRI_W = 7;
   localparam int unsigned TAG_W = 16;
   localparam int unsigned STAT_W = 2;
   localparam int unsigned OCC_W = 5;

   typedef logic [PRI_W-1:0] pri_type;
   typedef logic [TAG_W-1:0] tag_type;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_REMOVE = 1'b1
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_INSERTED = 2'd0,
      ST_SERVED   = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_REPLY
   } state_type;
endpackage
`default_nettype wire

// ===== rtl/spq_if.sv =====
`default_nettype none
interface spq_req_if import spq_pkg::*; ();
   logic    valid;
   logic    ready;
   logic    req_type;
   pri_type priority_req;
   tag_type order_tag;
   modport source (output valid, req_type, priority_req, order_tag, input ready);
   modport sink (input valid, req_type, priority_req, order_tag, output ready);
endinterface

interface spq_rsp_if import spq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   tag_type           served_tag;
   pri_type           served_priority;
   logic [OCC_W-1:0]  occupancy;
   modport source (output valid, status, served_tag, served_priority, occupancy,
                   input ready);
   modport sink (input valid, status, served_tag, served_priority, occupancy,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/sorted_priority_queue.sv =====
`default_nettype none
// Sorted-list priority queue of QUEUE_DEPTH entries. Each request word either
// inserts (priority, tag) or removes the head, which holds the largest
// priority; equal priorities leave in arrival order. Entries sit in one
// simple dual-port memory with a registered read port, read and written by a
// sequencer. A request is decoded in the idle state, then takes one memory
// step per entry touched: an insert scans from the head to its slot (pos+1
// reads, at most count) and then moves the tail up one slot per cycle and
// writes the new entry (count-pos+1 writes); a remove captures the head and
// moves every other held entry down one slot (count reads). The result word
// passes a reply state and is then held in an output register; the next
// request is taken once that register is free. The longest request is an
// insert into a queue holding QUEUE_DEPTH-1 entries.
// No clearing pass is needed: only slots below the count are ever read.
`include "assert_macros.svh"
module sorted_priority_queue import spq_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   spq_req_if.sink    req,
   spq_rsp_if.source  rsp
);
   localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

   // Entry memory: priority and tag side by side.
   logic [PRI_W+TAG_W-1:0] mem [QUEUE_DEPTH];
   logic [PRI_W+TAG_W-1:0] rd_data_ff;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [PRI_W+TAG_W-1:0] wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   state_type        state_ff, state_in;
   logic [CW-1:0]    count_ff, count_in;
   logic [CW-1:0]    idx_ff, idx_in;      // slot being read or moved
   logic             rd_pend_ff, rd_pend_in;
   pri_type          pri_ff, pri_in;
   tag_type          tag_ff, tag_in;
   logic [CW-1:0]    pos_ff, pos_in;      // insert slot
   status_type       stat_ff, stat_in;
   pri_type          spri_ff, spri_in;
   tag_type          stag_ff, stag_in;
   logic             ovalid_ff, ovalid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         rd_pend_ff <= 1'b0;
         ovalid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_pend_ff <= rd_pend_in;
         ovalid_ff  <= ovalid_in;
      end
      idx_ff  <= idx_in;
      pri_ff  <= pri_in;
      tag_ff  <= tag_in;
      pos_ff  <= pos_in;
      stat_ff <= stat_in;
      spri_ff <= spri_in;
      stag_ff <= stag_in;
   end

   logic    accept;
   pri_type rd_pri;
   tag_type rd_tag;
   assign rd_pri = rd_data_ff[PRI_W+TAG_W-1:TAG_W];
   assign rd_tag = rd_data_ff[TAG_W-1:0];

   assign req.ready = (state_ff == S_IDLE) && !ovalid_ff;
   assign accept    = req.valid && req.ready;

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      rd_pend_in = 1'b0;
      pri_in     = pri_ff;
      tag_in     = tag_ff;
      pos_in     = pos_ff;
      stat_in    = stat_ff;
      spri_in    = spri_ff;
      stag_in    = stag_ff;
      ovalid_in  = ovalid_ff;
      rd_en      = 1'b0;
      rd_addr    = idx_ff[AW-1:0];
      wr_en      = 1'b0;
      wr_addr    = idx_ff[AW-1:0];
      wr_data    = {pri_ff, tag_ff};

      if (ovalid_ff && rsp.ready) ovalid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pri_in  = req.priority_req;
               tag_in  = req.order_tag;
               spri_in = '0;
               stag_in = '0;
               idx_in  = '0;
               if (req.req_type == REQ_INSERT) begin
                  if (count_ff == DEPTH_C) begin
                     stat_in = ST_FULL;
                     state_in = S_REPLY;
                  end else begin
                     stat_in = ST_INSERTED;
                     if (count_ff == '0) begin
                        pos_in = '0;
                        idx_in = count_ff;
                        state_in = S_SHIFT_UP;
                     end else begin
                        // read head
                        rd_en = 1'b1;
                        rd_addr = '0;
                        rd_pend_in = 1'b1;
                        state_in = S_SCAN;
                     end
                  end
               end else begin
                  if (count_ff == '0) begin
                     stat_in = ST_EMPTY;
                     state_in = S_REPLY;
                  end else begin
                     stat_in = ST_SERVED;
                     rd_en = 1'b1;
                     rd_addr = '0;
                     rd_pend_in = 1'b1;
                     state_in = S_SHIFT_DOWN;
                  end
               end
            end
         end
         S_SCAN: begin
            // rd_data holds slot idx; advance while it outranks or ties
            if (rd_pri >= pri_ff && (idx_ff + 1'b1) < count_ff) begin
               idx_in = idx_ff + 1'b1;
               rd_en = 1'b1;
               rd_addr = idx_in[AW-1:0];
               rd_pend_in = 1'b1;
            end else begin
               pos_in = (rd_pri >= pri_ff) ? idx_ff + 1'b1 : idx_ff;
               idx_in = count_ff;
               state_in = S_SHIFT_UP;
               if (count_ff != ((rd_pri >= pri_ff) ? idx_ff + 1'b1 : idx_ff)) begin
                  rd_en = 1'b1;
                  rd_addr = AW'(count_ff - 1'b1);
                  rd_pend_in = 1'b1;
               end
            end
         end
         S_SHIFT_UP: begin
            // idx is the destination slot; rd_data holds slot idx-1
            if (idx_ff == pos_ff) begin
               wr_en = 1'b1;
               wr_addr = idx_ff[AW-1:0];
               wr_data = {pri_ff, tag_ff};
               count_in = count_ff + 1'b1;
               state_in = S_REPLY;
            end else begin
               wr_en = 1'b1;
               wr_addr = idx_ff[AW-1:0];
               wr_data = rd_data_ff;
               idx_in = idx_ff - 1'b1;
               if (idx_in != pos_ff) begin
                  rd_en = 1'b1;
                  rd_addr = AW'(idx_in - 1'b1);
                  rd_pend_in = 1'b1;
               end
            end
         end
         S_SHIFT_DOWN: begin
            // rd_data holds slot idx; move it to idx-1 (head is captured)
            if (idx_ff == '0) begin
               spri_in = rd_pri;
               stag_in = rd_tag;
            end else begin
               wr_en = 1'b1;
               wr_addr = AW'(idx_ff - 1'b1);
               wr_data = rd_data_ff;
            end
            if ((idx_ff + 1'b1) < count_ff) begin
               idx_in = idx_ff + 1'b1;
               rd_en = 1'b1;
               rd_addr = idx_in[AW-1:0];
               rd_pend_in = 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_REPLY;
            end
         end
         S_REPLY: begin
            ovalid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp.valid           = ovalid_ff;
   assign rsp.status          = stat_ff;
   assign rsp.served_tag      = stag_ff;
   assign rsp.served_priority = spri_ff;
   assign rsp.occupancy       = OCC_W'(count_ff);

   `ASSERT_CLK(a_count_bound, clock, reset, count_ff <= DEPTH_C,
      "count exceeds depth")
   `ASSERT_CLK(a_ready_when_idle, clock, reset,
      accept |=> (state_ff != S_IDLE), "request accepted without work")
   `ASSERT_CLK(a_read_pending, clock, reset,
      (state_ff == S_SCAN) |-> rd_pend_ff, "scan without read data")
   `ASSERT_CLK(a_count_step, clock, reset,
      (count_ff != $past(count_ff)) |->
      (count_ff == $past(count_ff) + 1'b1 || count_ff == $past(count_ff) - 1'b1),
      "count jumped")
endmodule
`default_nettype wire

// ===== tb/spq_tb_scoreboard.sv =====
`default_nettype none
package spq_tb_scoreboard_pkg;
   import spq_pkg::*;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      tag_type           served_tag;
      pri_type           served_priority;
      logic [OCC_W-1:0]  occupancy;
   } outcome_type;

   class queue_scoreboard;
      int unsigned depth;
      pri_type     held_pri[$];
      tag_type     held_tag[$];
      outcome_type pending[$];
      int          mismatches;

      function new(int unsigned d);
         depth = d;
         mismatches = 0;
      endfunction

      // Predict the outcome of one accepted request word.
      function void note_request(req_kind_type kind, pri_type p, tag_type t);
         outcome_type o;
         int pos;
         o = '0;
         if (kind == REQ_INSERT) begin
            if (held_pri.size() >= depth) begin
               o.status = ST_FULL;
            end else begin
               // go after every entry of greater or equal priority
               pos = 0;
               while (pos < held_pri.size() && held_pri[pos] >= p) pos++;
               held_pri.insert(pos, p);
               held_tag.insert(pos, t);
               o.status = ST_INSERTED;
            end
         end else if (held_pri.size() == 0) begin
            o.status = ST_EMPTY;
         end else begin
            o.status = ST_SERVED;
            o.served_priority = held_pri.pop_front();
            o.served_tag = held_tag.pop_front();
         end
         o.occupancy = OCC_W'(held_pri.size());
         pending.push_back(o);
      endfunction

      function int unsigned held_count();
         return held_pri.size();
      endfunction

      task report(string what, int unsigned got, int unsigned want);
         $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
         mismatches++;
      endtask

      task check_result(outcome_type got);
         outcome_type want;
         if (pending.size() == 0) begin
            report("unexpected result word", 1, 0);
         end else begin
            want = pending.pop_front();
            if (got.status !== want.status) report("status", got.status, want.status);
            if (got.served_tag !== want.served_tag)
               report("served_tag", got.served_tag, want.served_tag);
            if (got.served_priority !== want.served_priority)
               report("served_priority", got.served_priority, want.served_priority);
            if (got.occupancy !== want.occupancy)
               report("occupancy", got.occupancy, want.occupancy);
         end
      endtask
   endclass
endpackage
`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import spq_pkg::*;
   import spq_tb_scoreboard_pkg::*;

   localparam int unsigned DEPTH = 16;
   // the worst request, the receiver stalls and the long hold-off all fit below this
   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned RANDOM_WORDS = 1430;

   logic clock;
   logic reset;
   spq_req_if req ();
   spq_rsp_if rsp ();

   sorted_priority_queue #(.QUEUE_DEPTH(DEPTH)) i_dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source)
   );

   queue_scoreboard sb;
   logic  sending_done;
   logic  calm;          // no idling in the last part of the run
   logic  hold_off;      // long receiver hold-off requested
   int unsigned quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      sb = new(DEPTH);
      reset = 1'b1;
      req.valid = 1'b0;
      req.req_type = 1'b0;
      req.priority_req = '0;
      req.order_tag = '0;
      rsp.ready = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
   end

   // Offer one word and hold it until accepted; valid stays high across words.
   task send_word(req_kind_type kind, pri_type p, tag_type t);
      req.valid <= 1'b1;
      req.req_type <= kind;
      req.priority_req <= p;
      req.order_tag <= t;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sb.note_request(kind, p, t);
   endtask

   // Drop valid for a random burst now and then.
   task maybe_idle();
      int n;
      if (!calm && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 16);
         req.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task send_insert(pri_type p, tag_type t);
      send_word(REQ_INSERT, p, t);
      maybe_idle();
   endtask

   task send_remove();
      send_word(REQ_REMOVE, pri_type'($urandom), tag_type'($urandom));
      maybe_idle();
   endtask

   // Stimulus: directed corners, then random phases with a swept insert bias.
   initial begin
      int bias;
      sending_done = 1'b0;
      calm = 1'b0;
      hold_off = 1'b0;
      @(negedge reset);
      @(posedge clock);
      // remove from empty
      send_remove();
      // extremes of fields and equal priorities in arrival order
      send_insert(7'd0, 16'h0000);
      send_insert(7'd127, 16'hFFFF);
      send_insert(7'd127, 16'h5555);
      send_insert(7'd0, 16'hAAAA);
      send_insert(7'h55, 16'h1234);
      send_insert(7'h2A, 16'hFEDC);
      repeat (6) send_remove();
      send_remove();
      // fill to full, then refuse one insert
      for (int i = 0; i < DEPTH; i++) send_insert(pri_type'(i % 3 * 50), tag_type'(i));
      send_insert(7'd127, 16'hBEEF);
      // with the receiver held off, keep offering so the block backs up
      hold_off = 1'b1;
      repeat (DEPTH) send_remove();
      hold_off = 1'b0;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (i == RANDOM_WORDS - 150) calm = 1'b1;
         // sweep the fill bias so both full and empty are reached often
         bias = ((i / 100) % 3 == 0) ? 75 : ((i / 100) % 3 == 1) ? 35 : 55;
         if ($urandom_range(0, 99) < bias) begin
            // narrow priority range at times to force many ties
            if ($urandom_range(0, 1))
               send_insert(pri_type'($urandom_range(60, 63)), tag_type'($urandom));
            else
               send_insert(pri_type'($urandom), tag_type'($urandom));
         end else begin
            send_remove();
         end
      end
      req.valid <= 1'b0;
      sending_done = 1'b1;
   end

   // Receiver: random stalls, plus one long hold-off counted here.
   initial begin
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp.ready <= 1'b0;
            repeat (400) @(posedge clock);
            rsp.ready <= 1'b1;
            wait (!hold_off);
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 16);
            rsp.ready <= 1'b0;
            repeat (n) @(posedge clock);
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= 1'b1;
         end
      end
   end

   // Check each accepted result word.
   always @(posedge clock) begin
      outcome_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.status = rsp.status;
         got.served_tag = rsp.served_tag;
         got.served_priority = rsp.served_priority;
         got.occupancy = rsp.occupancy;
         sb.check_result(got);
      end
   end

   // Watchdog: count cycles with no word accepted on either side.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      @(negedge reset);
      fork
         begin
            while (!(sending_done && sb.pending.size() == 0)) @(posedge clock);
            repeat (2 * DEPTH + 10) @(posedge clock);
         end
         begin
            wait (quiet_cycles >= STALL_LIMIT);
            $display("timeout: no word accepted for %0d cycles", STALL_LIMIT);
            sb.mismatches++;
         end
      join_any
      if (sb.mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire
